// ===== rtl/core/pcm_pkg.sv =====
// Package with the types, codes and helper functions of the PIN retry counter engine.
`timescale 1ns / 1ps
package pcm_pkg;

  localparam int ENTRIES   = 16;
  localparam int PIN_BYTES = 8;
  localparam int PIN_W     = 8 * PIN_BYTES;
  localparam int IDX_W     = $clog2(ENTRIES);

  localparam logic [7:0]  REF_ALWAYS   = 8'h90;
  localparam logic [31:0] VERIFIED_RST = 32'h8000_0000;

  typedef enum logic [3:0] {
    OP_VERIFY        = 4'd0,
    OP_VERIFY_COUNT  = 4'd1,
    OP_CHANGE        = 4'd2,
    OP_UNBLOCK       = 4'd3,
    OP_UNBLOCK_COUNT = 4'd4,
    OP_ENABLE        = 4'd5,
    OP_DISABLE       = 4'd6,
    OP_QUERY         = 4'd7,
    OP_LOAD          = 4'd8
  } op_t;

  typedef enum logic [2:0] {
    ST_VERIFIED     = 3'd0,
    ST_NOT_VERIFIED = 3'd1,
    ST_BLOCKED      = 3'd2,
    ST_BAD_STATE    = 3'd3,
    ST_NOT_FOUND    = 3'd4,
    ST_BAD_REF      = 3'd5,
    ST_DONE         = 3'd6
  } status_t;

  typedef struct packed {
    logic [7:0]       key;
    logic             en;
    logic [3:0]       ulim;
    logic [3:0]       vlim;
    logic [3:0]       ucnt;
    logic [3:0]       vcnt;
    logic [PIN_W-1:0] vpin;
    logic [PIN_W-1:0] upin;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic             valid;
    entry_t           data;
  } tbl_wr_t;

  typedef struct packed {
    logic [3:0]  op;
    logic [7:0]  key_ref;
    logic [63:0] pin_value;
    logic [63:0] new_pin;
    logic        expected_enabled;
  } cmd_t;

  typedef struct packed {
    logic       key_verified;
    logic       pin_state;
    logic [3:0] attempts;
    logic [2:0] status;
  } res_t;

  typedef struct packed {
    logic   wr;
    entry_t ent;
    logic   set_bit;
    res_t   res;
  } exec_t;

  function automatic logic ref_ok(input logic [7:0] r);
    logic hi_ok;
    logic lo_ok;
    hi_ok = (r[7:4] == 4'h0) || (r[7:4] == 4'h8);
    lo_ok = (r[3:0] != 4'h0) && (r[3:0] != 4'h9) && (r[3:0] != 4'hF);
    return hi_ok && lo_ok;
  endfunction

  function automatic logic ref_adm(input logic [7:0] r);
    return ((r >= 8'h0A) && (r <= 8'h0E)) || ((r >= 8'h8A) && (r <= 8'h8E));
  endfunction

  function automatic logic [4:0] ref_pos(input logic [7:0] r);
    logic [7:0] p;
    p = (r < 8'h81) ? (r - 8'h01) : (r - 8'h71);
    return p[4:0];
  endfunction

endpackage

// ===== rtl/core/pin_retry_counter_manager_unit.sv =====
// Top level of the PIN retry counter engine: command sequencer, verified bitmap and output stage.
//
// Channel | Direction | Handshake         | Payload
// in_     | input     | in_tvalid/tready  | in_tuser op, in_tdata command fields
// out_    | output    | out_tvalid/tready | out_tdata status, attempts, flags
//
// A command that needs the table scans the table memory sequentially, one read per cycle, until
// a matching entry is found or the last entry has been compared.
// Load and rejected commands skip the scan and go straight to the response state.
// Reset is synchronous and active low; it clears the valid flags and returns the bitmap to the
// always bit.
// A new command is taken while a result waits on the output register.
`timescale 1ns / 1ps
module pin_retry_counter_manager_unit
  import pcm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [3:0]   in_tuser,   // op
  input  logic [151:0] in_tdata,   // key_ref, pin_value, new_pin, expected_enabled, slot,
                                   // verify_limit, unblock_limit, load_enabled, load_valid
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [15:0]  out_tdata   // status, attempts, pin_state, key_verified
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_EXEC = 4'b0100,
    S_RESP = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  res_t               res_r, res_nxt;
  res_t               out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [IDX_W:0]     idx_r, idx_nxt;
  logic [IDX_W-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic [31:0]        verified_r, verified_nxt;

  cmd_t               in_cmd;
  logic [3:0]         in_slot;
  logic [3:0]         in_vlim;
  logic [3:0]         in_ulim;
  logic               in_len;
  logic               in_lval;
  logic               accept;
  logic               out_free;
  logic               match;
  logic [4:0]         pos;

  tbl_wr_t            tbl_wr;
  logic               rd_en;
  entry_t             rd_data;
  logic [ENTRIES-1:0] valid;
  exec_t              ex;

  assign in_cmd.op               = in_tuser;
  assign in_cmd.key_ref          = in_tdata[7:0];
  assign in_cmd.pin_value        = in_tdata[71:8];
  assign in_cmd.new_pin          = in_tdata[135:72];
  assign in_cmd.expected_enabled = in_tdata[136];
  assign in_slot                 = in_tdata[140:137];
  assign in_vlim                 = in_tdata[144:141];
  assign in_ulim                 = in_tdata[148:145];
  assign in_len                  = in_tdata[149];
  assign in_lval                 = in_tdata[150];

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign pos       = ref_pos(cmd_r.key_ref);
  assign rd_en     = (state_r == S_SCAN) && (idx_r < (IDX_W + 1)'(ENTRIES)) && !match;
  assign match     = (state_r == S_SCAN) && cmp_vld_r && valid[cmp_idx_r]
                     && (rd_data.key == cmd_r.key_ref);

  pcm_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (tbl_wr),
    .rd_en   (rd_en),
    .rd_addr (idx_r[IDX_W-1:0]),
    .rd_data (rd_data),
    .valid   (valid)
  );

  pcm_exec u_exec (
    .cmd  (cmd_r),
    .ent  (rd_data),
    .vbit (verified_r[pos]),
    .ex   (ex)
  );

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_tready;
    idx_nxt       = idx_r;
    cmp_idx_nxt   = cmp_idx_r;
    cmp_vld_nxt   = cmp_vld_r;
    verified_nxt  = verified_r;
    tbl_wr        = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt     = in_cmd;
          res_nxt     = '0;
          idx_nxt     = '0;
          cmp_vld_nxt = 1'b0;
          state_nxt   = S_RESP;
          case (in_cmd.op)
            OP_LOAD: begin
              if (in_lval && !ref_ok(in_cmd.key_ref)) begin
                res_nxt.status = ST_BAD_REF;
              end else if (32'(in_slot) >= ENTRIES) begin
                res_nxt.status = ST_NOT_FOUND;
              end else begin
                tbl_wr.en          = 1'b1;
                tbl_wr.addr        = in_slot[IDX_W-1:0];
                tbl_wr.valid       = in_lval;
                tbl_wr.data.key    = in_cmd.key_ref;
                tbl_wr.data.en     = in_len;
                tbl_wr.data.vcnt   = in_vlim;
                tbl_wr.data.ucnt   = in_ulim;
                tbl_wr.data.vlim   = in_vlim;
                tbl_wr.data.ulim   = in_ulim;
                tbl_wr.data.vpin   = in_cmd.pin_value[PIN_W-1:0];
                tbl_wr.data.upin   = in_cmd.new_pin[PIN_W-1:0];
                res_nxt.status     = ST_DONE;
                res_nxt.pin_state  = in_lval && in_len;
              end
            end
            OP_QUERY: begin
              if (!ref_ok(in_cmd.key_ref) && (in_cmd.key_ref != REF_ALWAYS)) begin
                res_nxt.status = ST_BAD_REF;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            OP_VERIFY, OP_VERIFY_COUNT, OP_ENABLE, OP_DISABLE: begin
              if (!ref_ok(in_cmd.key_ref)) begin
                res_nxt.status = ST_BAD_REF;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            OP_CHANGE, OP_UNBLOCK, OP_UNBLOCK_COUNT: begin
              if (!ref_ok(in_cmd.key_ref)) begin
                res_nxt.status = ST_BAD_REF;
              end else if (ref_adm(in_cmd.key_ref)) begin
                res_nxt.status = ST_BAD_STATE;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              res_nxt.status = ST_BAD_STATE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (match) begin
          cmp_vld_nxt = 1'b0;
          state_nxt   = S_EXEC;
        end else if (cmp_vld_r && (cmp_idx_r == IDX_W'(ENTRIES - 1))) begin
          cmp_vld_nxt = 1'b0;
          res_nxt     = '0;
          if (cmd_r.op == OP_QUERY) begin
            res_nxt.status       = ST_DONE;
            res_nxt.key_verified = verified_r[pos];
          end else begin
            res_nxt.status = ST_NOT_FOUND;
          end
          state_nxt = S_RESP;
        end else begin
          cmp_vld_nxt = rd_en;
          cmp_idx_nxt = idx_r[IDX_W-1:0];
          if (rd_en) begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      S_EXEC: begin
        tbl_wr.en    = ex.wr;
        tbl_wr.addr  = cmp_idx_r;
        tbl_wr.valid = 1'b1;
        tbl_wr.data  = ex.ent;
        if (ex.set_bit) begin
          verified_nxt[pos] = 1'b1;
        end
        res_nxt   = ex.res;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
      idx_r       <= '0;
      verified_r  <= VERIFIED_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      idx_r       <= idx_nxt;
      verified_r  <= verified_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
    cmp_idx_r <= cmp_idx_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_r.key_verified, out_r.pin_state, out_r.attempts,
                       out_r.status};

  a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_wr.en |-> ((state_r == S_IDLE) || (state_r == S_EXEC)))
    else $error("Table written outside a load or an execute cycle.");

  a_rd_state: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (state_r == S_SCAN))
    else $error("Table read outside the scan.");

  a_always_bit: assert property (@(posedge clk) disable iff (!rst_n)
    verified_r[31])
    else $error("The always bit of the verified bitmap has been lost.");

  a_exec_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> (valid[cmp_idx_r] && (rd_data.key == cmd_r.key_ref)))
    else $error("Execute stage entered without a matching entry.");

endmodule

// ===== rtl/core/pcm_table.sv =====
// Key entry table: one synchronous memory with registered read and per-entry valid flags.
`timescale 1ns / 1ps
module pcm_table
  import pcm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  tbl_wr_t            wr,
  input  logic               rd_en,
  input  logic [IDX_W-1:0]   rd_addr,
  output entry_t             rd_data,
  output logic [ENTRIES-1:0] valid
);

  entry_t             mem [ENTRIES];
  entry_t             rd_data_r;
  logic [ENTRIES-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (wr.en && wr.valid) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.addr] <= wr.valid;
    end
  end

  assign rd_data = rd_data_r;
  assign valid   = valid_r;

endmodule

// ===== rtl/core/pcm_exec.sv =====
// Command execution on a found entry: retry counters, PIN compare and entry update.
`timescale 1ns / 1ps
module pcm_exec
  import pcm_pkg::*;
(
  input  cmd_t   cmd,
  input  entry_t ent,
  input  logic   vbit,
  output exec_t  ex
);

  logic             need;
  logic             use_ub;
  logic [3:0]       cnt;
  logic [3:0]       cnt_dec;
  logic [PIN_W-1:0] stored;
  logic             pin_eq;

  always_comb begin
    need    = (cmd.op == OP_VERIFY) ? cmd.expected_enabled : (cmd.op == OP_DISABLE);
    use_ub  = (cmd.op == OP_UNBLOCK);
    cnt     = use_ub ? ent.ucnt : ent.vcnt;
    cnt_dec = cnt - 4'd1;
    stored  = use_ub ? ent.upin : ent.vpin;
    pin_eq  = (cmd.pin_value[PIN_W-1:0] == stored);

    ex              = '0;
    ex.ent          = ent;
    ex.res.status   = ST_BAD_STATE;

    case (cmd.op)
      OP_VERIFY_COUNT: begin
        ex.res.status   = ST_NOT_VERIFIED;
        ex.res.attempts = ent.vcnt;
      end
      OP_UNBLOCK_COUNT: begin
        ex.res.status   = ST_NOT_VERIFIED;
        ex.res.attempts = ent.ucnt;
      end
      OP_QUERY: begin
        ex.res.status       = ST_DONE;
        ex.res.key_verified = vbit;
      end
      OP_VERIFY, OP_ENABLE, OP_DISABLE, OP_CHANGE, OP_UNBLOCK: begin
        if (((cmd.op == OP_VERIFY) || (cmd.op == OP_ENABLE) || (cmd.op == OP_DISABLE))
            && (ent.en != need)) begin
          ex.res.status = ST_BAD_STATE;
        end else if ((cmd.op == OP_CHANGE) && !ent.en) begin
          ex.res.status = ST_BAD_STATE;
        end else if (cnt == 4'd0) begin
          ex.res.status = ST_BLOCKED;
        end else begin
          ex.wr = 1'b1;
          if (!pin_eq) begin
            ex.res.status   = ST_NOT_VERIFIED;
            ex.res.attempts = cnt_dec;
            if (use_ub) begin
              ex.ent.ucnt = cnt_dec;
            end else begin
              ex.ent.vcnt = cnt_dec;
            end
          end else begin
            ex.res.status = ST_VERIFIED;
            ex.set_bit    = 1'b1;
            if (use_ub) begin
              ex.ent.ucnt = ent.ulim;
            end else begin
              ex.ent.vcnt = ent.vlim;
            end
            if (cmd.op == OP_ENABLE) begin
              ex.ent.en = 1'b1;
            end else if (cmd.op == OP_DISABLE) begin
              ex.ent.en = 1'b0;
            end else if ((cmd.op == OP_CHANGE) || (cmd.op == OP_UNBLOCK)) begin
              ex.ent.vpin = cmd.new_pin[PIN_W-1:0];
              ex.ent.vcnt = ent.vlim;
              ex.ent.en   = 1'b1;
            end
          end
        end
      end
      default: begin
        ex.res.status = ST_BAD_STATE;
      end
    endcase

    ex.res.pin_state = ex.ent.en;
  end

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the PIN retry counter engine with a table walk and random commands.
`timescale 1ns / 1ps
module testbench;
  import pcm_pkg::*;

  typedef struct packed {
    logic [3:0]  op;
    logic [7:0]  key_ref;
    logic [63:0] pin_value;
    logic [63:0] new_pin;
    logic        expected_enabled;
    logic [3:0]  slot;
    logic [3:0]  verify_limit;
    logic [3:0]  unblock_limit;
    logic        load_enabled;
    logic        load_valid;
  } command_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] attempts;
    logic       pin_state;
    logic       key_verified;
  } answer_t;

  typedef struct {
    command_t cmd;
    logic     typed;
    answer_t  ans;
  } row_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [3:0]   in_tuser;
  logic [151:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [15:0]  out_tdata;

  logic [8:0]  key_tab [ENTRIES];
  logic        en_tab [ENTRIES];
  logic [3:0]  vcnt_tab [ENTRIES];
  logic [3:0]  ucnt_tab [ENTRIES];
  logic [3:0]  vlim_tab [ENTRIES];
  logic [3:0]  ulim_tab [ENTRIES];
  logic [63:0] vpin_tab [ENTRIES];
  logic [63:0] upin_tab [ENTRIES];
  logic [31:0] verified_map;
  answer_t     pending_answers [$];
  int          failures;
  int          stall_left;
  logic        stimulus_done;

  pin_retry_counter_manager_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #4 clk = ~clk;

  function automatic logic key_valid(input logic [7:0] r);
    return (r[7:4] == 4'h0 || r[7:4] == 4'h8) && r[3:0] != 4'h0 && r[3:0] != 4'h9 &&
           r[3:0] != 4'hF;
  endfunction

  function automatic logic key_admin(input logic [7:0] r);
    return (r >= 8'h0A && r <= 8'h0E) || (r >= 8'h8A && r <= 8'h8E);
  endfunction

  function automatic logic [31:0] key_mask(input logic [7:0] r);
    logic [7:0] p;
    p = (r < 8'h81) ? r - 8'h01 : r - 8'h71;
    return 32'h1 << p[4:0];
  endfunction

  function automatic int lookup_key(input logic [7:0] r);
    for (int i = 0; i < ENTRIES; i++)
      if (key_tab[i] == {1'b1, r}) return i;
    return -1;
  endfunction

  function automatic answer_t execute_command(input command_t c);
    answer_t a;
    int e;
    logic need;
    logic [3:0] cnt;
    a = '{status: ST_BAD_STATE, attempts: 0, pin_state: 0, key_verified: 0};
    if (c.op == OP_LOAD) begin
      if (c.load_valid && !key_valid(c.key_ref)) a.status = ST_BAD_REF;
      else if (c.slot >= ENTRIES) a.status = ST_NOT_FOUND;
      else if (!c.load_valid) begin
        key_tab[c.slot] = '0;
        en_tab[c.slot] = 1'b0;
        a.status = ST_DONE;
      end else begin
        key_tab[c.slot] = {1'b1, c.key_ref};
        en_tab[c.slot] = c.load_enabled;
        vcnt_tab[c.slot] = c.verify_limit;
        vlim_tab[c.slot] = c.verify_limit;
        ucnt_tab[c.slot] = c.unblock_limit;
        ulim_tab[c.slot] = c.unblock_limit;
        vpin_tab[c.slot] = c.pin_value;
        upin_tab[c.slot] = c.new_pin;
        a.pin_state = c.load_enabled;
        a.status = ST_DONE;
      end
    end else if (c.op == OP_QUERY) begin
      if (!key_valid(c.key_ref) && c.key_ref != REF_ALWAYS) a.status = ST_BAD_REF;
      else begin
        e = lookup_key(c.key_ref);
        if (e >= 0) a.pin_state = en_tab[e];
        a.key_verified = (verified_map & key_mask(c.key_ref)) != 0;
        a.status = ST_DONE;
      end
    end else if (c.op <= OP_DISABLE) begin
      e = lookup_key(c.key_ref);
      if (!key_valid(c.key_ref)) a.status = ST_BAD_REF;
      else if (c.op inside {OP_CHANGE, OP_UNBLOCK, OP_UNBLOCK_COUNT} && key_admin(c.key_ref))
        a.status = ST_BAD_STATE;
      else if (e < 0) a.status = ST_NOT_FOUND;
      else begin
        if (c.op == OP_VERIFY_COUNT) begin
          a.status = ST_NOT_VERIFIED;
          a.attempts = vcnt_tab[e];
        end else if (c.op == OP_UNBLOCK_COUNT) begin
          a.status = ST_NOT_VERIFIED;
          a.attempts = ucnt_tab[e];
        end else if (c.op == OP_CHANGE && !en_tab[e]) begin
          a.status = ST_BAD_STATE;
        end else begin
          need = (c.op == OP_VERIFY) ? c.expected_enabled : (c.op == OP_DISABLE);
          cnt = (c.op == OP_UNBLOCK) ? ucnt_tab[e] : vcnt_tab[e];
          if (c.op inside {OP_VERIFY, OP_ENABLE, OP_DISABLE} && en_tab[e] != need)
            a.status = ST_BAD_STATE;
          else if (cnt == 4'd0) a.status = ST_BLOCKED;
          else if (c.pin_value != ((c.op == OP_UNBLOCK) ? upin_tab[e] : vpin_tab[e])) begin
            a.status = ST_NOT_VERIFIED;
            a.attempts = cnt - 4'd1;
            if (c.op == OP_UNBLOCK) ucnt_tab[e] = cnt - 4'd1;
            else vcnt_tab[e] = cnt - 4'd1;
          end else begin
            a.status = ST_VERIFIED;
            verified_map |= key_mask(c.key_ref);
            if (c.op == OP_UNBLOCK) ucnt_tab[e] = ulim_tab[e];
            vcnt_tab[e] = vlim_tab[e];
            if (c.op == OP_ENABLE) en_tab[e] = 1'b1;
            else if (c.op == OP_DISABLE) en_tab[e] = 1'b0;
            else if (c.op == OP_CHANGE || c.op == OP_UNBLOCK) begin
              vpin_tab[e] = c.new_pin;
              en_tab[e] = 1'b1;
            end
          end
        end
        a.pin_state = en_tab[e];
      end
    end
    return a;
  endfunction

  task automatic send_command(input command_t c, input logic typed, input answer_t want);
    answer_t a;
    a = execute_command(c);
    if (typed && a !== want)
      $error("table row disagrees with prediction: expected %h, predicted %h", want, a);
    if ($urandom_range(0, 3) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3))
        @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= c.op;
    in_tdata <= {c.load_valid, c.load_enabled, c.unblock_limit, c.verify_limit, c.slot,
                 c.expected_enabled, c.new_pin, c.pin_value, c.key_ref};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_answers.push_back(a);
  endtask

  function automatic command_t random_command(input logic wide);
    command_t c;
    logic [7:0] keys [4] = '{8'h01, 8'h0A, 8'h85, 8'h8E};
    c.op = 4'($urandom_range(0, 20) == 0 ? $urandom_range(9, 15) : $urandom_range(0, 8));
    c.key_ref = $urandom_range(0, 9) == 0 ? 8'($urandom_range(0, 255))
                                          : keys[$urandom_range(0, 3)];
    if (wide) c.key_ref = 8'($urandom_range(0, 255));
    c.pin_value = $urandom_range(0, 1) ? {$urandom, $urandom} : 64'($urandom_range(0, 2));
    c.new_pin = $urandom_range(0, 1) ? {$urandom, $urandom} : 64'($urandom_range(0, 2));
    c.expected_enabled = 1'($urandom);
    c.slot = 4'($urandom);
    c.verify_limit = 4'($urandom_range(0, 4) == 0 ? $urandom : $urandom_range(1, 3));
    c.unblock_limit = 4'($urandom_range(0, 4) == 0 ? $urandom : $urandom_range(1, 3));
    c.load_enabled = 1'($urandom);
    c.load_valid = $urandom_range(0, 7) != 0;
    return c;
  endfunction

  always @(posedge clk) begin
    answer_t got;
    answer_t want;
    if (rst_n) begin
      if (stall_left > 0) stall_left--;
      else if ($urandom_range(0, 3) == 0)
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      out_tready <= (stall_left == 0) || stimulus_done;
      if (out_tvalid && out_tready) begin
        got = '{status: out_tdata[2:0], attempts: out_tdata[6:3], pin_state: out_tdata[7],
                key_verified: out_tdata[8]};
        if (pending_answers.size() == 0) begin
          $error("unexpected transaction on the result channel: %h", out_tdata);
          failures++;
        end else begin
          want = pending_answers.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            failures++;
          end
          if (got.attempts !== want.attempts) begin
            $error("attempts: expected %0d, actual %0d", want.attempts, got.attempts);
            failures++;
          end
          if (got.pin_state !== want.pin_state) begin
            $error("pin_state: expected %0d, actual %0d", want.pin_state, got.pin_state);
            failures++;
          end
          if (got.key_verified !== want.key_verified) begin
            $error("key_verified: expected %0d, actual %0d", want.key_verified,
                   got.key_verified);
            failures++;
          end
        end
      end
    end
  end

  initial begin
    row_t rows [$];
    command_t c;
    answer_t none;
    none = '0;
    clk = 0;
    rst_n = 0;
    in_tvalid = 0;
    in_tuser = '0;
    in_tdata = '0;
    out_tready = 0;
    failures = 0;
    stall_left = 0;
    stimulus_done = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      key_tab[i] = '0;
      en_tab[i] = 1'b0;
    end
    verified_map = VERIFIED_RST;
    c = '0;
    c.op = OP_QUERY; c.key_ref = REF_ALWAYS;
    rows.push_back('{c, 1, '{ST_DONE, 0, 0, 1}});
    c.op = OP_QUERY; c.key_ref = 8'h01;
    rows.push_back('{c, 1, '{ST_DONE, 0, 0, 0}});
    c.op = OP_VERIFY; c.key_ref = 8'hFF;
    rows.push_back('{c, 1, '{ST_BAD_REF, 0, 0, 0}});
    c.op = OP_VERIFY; c.key_ref = 8'h00;
    rows.push_back('{c, 1, '{ST_BAD_REF, 0, 0, 0}});
    c.op = OP_VERIFY; c.key_ref = 8'h01;
    rows.push_back('{c, 1, '{ST_NOT_FOUND, 0, 0, 0}});
    c.op = OP_CHANGE; c.key_ref = 8'h0A;
    rows.push_back('{c, 1, '{ST_BAD_STATE, 0, 0, 0}});
    c.op = 4'hF;
    rows.push_back('{c, 1, '{ST_BAD_STATE, 0, 0, 0}});
    c = '{OP_LOAD, 8'h90, '1, '1, 1'b0, 4'd0, 4'd2, 4'd2, 1'b1, 1'b1};
    rows.push_back('{c, 1, '{ST_BAD_REF, 0, 0, 0}});
    c = '{OP_LOAD, 8'h01, '1, '0, 1'b0, 4'd15, 4'd2, 4'd15, 1'b1, 1'b1};
    rows.push_back('{c, 1, '{ST_DONE, 0, 1, 0}});
    c = '{OP_LOAD, 8'h8E, 64'h5, 64'h6, 1'b0, 4'd0, 4'd1, 4'd1, 1'b0, 1'b1};
    rows.push_back('{c, 1, '{ST_DONE, 0, 0, 0}});
    rows.push_back('{'{OP_VERIFY, 8'h01, 64'h1, '0, 1'b1, 0, 0, 0, 0, 0}, 0, none});
    rows.push_back('{'{OP_VERIFY, 8'h01, '1, '0, 1'b0, 0, 0, 0, 0, 0}, 0, none});
    rows.push_back('{'{OP_VERIFY, 8'h01, 64'h1, '0, 1'b1, 0, 0, 0, 0, 0}, 0, none});
    rows.push_back('{'{OP_VERIFY_COUNT, 8'h01, 0, 0, 0, 0, 0, 0, 0, 0}, 0, none});
    rows.push_back('{'{OP_UNBLOCK, 8'h01, 64'h0, 64'h7, 0, 0, 0, 0, 0, 0}, 0, none});
    rows.push_back('{'{OP_UNBLOCK_COUNT, 8'h01, 0, 0, 0, 0, 0, 0, 0, 0}, 0, none});
    rows.push_back('{'{OP_CHANGE, 8'h01, 64'h7, '1, 0, 0, 0, 0, 0, 0}, 0, none});
    rows.push_back('{'{OP_DISABLE, 8'h01, '1, 0, 0, 0, 0, 0, 0, 0}, 0, none});
    rows.push_back('{'{OP_ENABLE, 8'h8E, 64'h5, 0, 0, 0, 0, 0, 0, 0}, 0, none});
    rows.push_back('{'{OP_ENABLE, 8'h8E, 64'h5, 0, 0, 0, 0, 0, 0, 0}, 0, none});
    rows.push_back('{'{OP_UNBLOCK_COUNT, 8'h8E, 0, 0, 0, 0, 0, 0, 0, 0}, 0, none});
    rows.push_back('{'{OP_QUERY, 8'h8E, 0, 0, 0, 0, 0, 0, 0, 0}, 0, none});
    rows.push_back('{'{OP_LOAD, 8'hAB, 0, 0, 0, 4'd15, 0, 0, 0, 1'b0}, 1,
                     '{ST_DONE, 0, 0, 0}});
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (rows[i]) send_command(rows[i].cmd, rows[i].typed, rows[i].ans);
    for (int n = 0; n < 680; n++) begin
      if (n == 300) begin
        in_tvalid <= 0;
        @(posedge clk);
        while (pending_answers.size() != 0) @(posedge clk);
      end
      send_command(random_command(n % 50 == 0), 0, none);
    end
    in_tvalid <= 0;
    stimulus_done = 1;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (failures == 0 && pending_answers.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
